// ----- rtl/xpcu_pkg.sv -----
// Shared types and constants for the packed pattern cell unpacker.
package xpcu_pkg;

  // Lead byte flag and field mask layout
  localparam logic [7:0] LEAD_MASK_FLAG  = 8'h80;
  localparam logic [4:0] FIELD_BITS      = 5'h1F;
  localparam logic [4:0] PLAIN_FOLLOW    = 5'h1E;
  localparam logic [7:0] EMPTY_KEY_RESET = 8'd97;

  // One-hot field bits within the mask
  localparam logic [4:0] FB_KEY   = 5'b00001;
  localparam logic [4:0] FB_INST  = 5'b00010;
  localparam logic [4:0] FB_VOL   = 5'b00100;
  localparam logic [4:0] FB_EFF   = 5'b01000;
  localparam logic [4:0] FB_PARAM = 5'b10000;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Parser phase of the front end
  typedef enum logic {
    PH_LEAD,
    PH_BODY
  } phase_t;

  // Which field a classified word fills
  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY,
    OP_INST,
    OP_VOL,
    OP_EFF,
    OP_PARAM
  } op_kind_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic       start;
    logic       last;
    op_kind_t   kind;
    logic [7:0] data;
  } cell_op_t;

endpackage

// ----- rtl/xpcu_front.sv -----
// Front end: accepts stream words, tracks the cell mask, classifies each word.
module xpcu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        data_byte,
  output xpcu_pkg::cell_op_t op
);

  xpcu_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]       mask_r, mask_nxt;
  logic [4:0]       lowest;
  logic [4:0]       remaining;
  logic [4:0]       lead_mask;

  // Pick the lowest announced field
  assign lowest    = mask_r & (~mask_r + 5'd1);
  assign remaining = mask_r & ~lowest;
  assign lead_mask = data_byte[4:0] & xpcu_pkg::FIELD_BITS;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    if (push) begin
      case (phase_r)
        xpcu_pkg::PH_LEAD: begin
          if ((data_byte & xpcu_pkg::LEAD_MASK_FLAG) != 8'd0) begin
            mask_nxt  = lead_mask;
            phase_nxt = (lead_mask == 5'd0) ? xpcu_pkg::PH_LEAD : xpcu_pkg::PH_BODY;
          end else begin
            mask_nxt  = xpcu_pkg::PLAIN_FOLLOW;
            phase_nxt = xpcu_pkg::PH_BODY;
          end
        end
        xpcu_pkg::PH_BODY: begin
          mask_nxt  = remaining;
          phase_nxt = (remaining == 5'd0) ? xpcu_pkg::PH_LEAD : xpcu_pkg::PH_BODY;
        end
        default: begin
          mask_nxt  = 5'd0;
          phase_nxt = xpcu_pkg::PH_LEAD;
        end
      endcase
    end
  end

  // Classify the current word
  always_comb begin
    op.data  = data_byte;
    op.start = 1'b0;
    op.last  = 1'b0;
    op.kind  = xpcu_pkg::OP_NONE;
    case (phase_r)
      xpcu_pkg::PH_LEAD: begin
        op.start = 1'b1;
        if ((data_byte & xpcu_pkg::LEAD_MASK_FLAG) != 8'd0) begin
          op.kind = xpcu_pkg::OP_NONE;
          op.last = (lead_mask == 5'd0);
        end else begin
          op.kind = xpcu_pkg::OP_KEY;
        end
      end
      xpcu_pkg::PH_BODY: begin
        op.last = (remaining == 5'd0);
        case (lowest)
          xpcu_pkg::FB_KEY:   op.kind = xpcu_pkg::OP_KEY;
          xpcu_pkg::FB_INST:  op.kind = xpcu_pkg::OP_INST;
          xpcu_pkg::FB_VOL:   op.kind = xpcu_pkg::OP_VOL;
          xpcu_pkg::FB_EFF:   op.kind = xpcu_pkg::OP_EFF;
          xpcu_pkg::FB_PARAM: op.kind = xpcu_pkg::OP_PARAM;
          default:            op.kind = xpcu_pkg::OP_NONE;
        endcase
      end
      default: begin
        op.kind = xpcu_pkg::OP_NONE;
      end
    endcase
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xpcu_pkg::PH_LEAD;
      mask_r  <= 5'd0;
    end else begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule

// ----- rtl/xpcu_queue.sv -----
// Short FIFO of classified words between front and back.
module xpcu_queue #(
  parameter int DEPTH = xpcu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  xpcu_pkg::cell_op_t push_op,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output xpcu_pkg::cell_op_t head_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xpcu_pkg::cell_op_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/xpcu_back.sv -----
// Back end: latches fields from classified words and registers finished cells.
module xpcu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  xpcu_pkg::cell_op_t op,
  output logic               pop,
  input  logic [7:0]         empty_key_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         cell_key,
  output logic [7:0]         cell_instrument,
  output logic [7:0]         cell_volume,
  output logic [7:0]         cell_effect,
  output logic [7:0]         cell_param
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] held_key_r, held_inst_r, held_vol_r, held_eff_r;
  logic [7:0] key_nxt, inst_nxt, vol_nxt, eff_nxt, param_nxt;
  logic [7:0] key_out;
  logic [7:0] key_r, inst_r, vol_r, eff_r, param_r;
  logic       out_free;

  // Take a word unless it closes a cell and the output is still occupied
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = op_valid && (!op.last || out_free);

  // Merge the word into the held fields
  always_comb begin
    key_nxt   = op.start ? 8'd0 : held_key_r;
    inst_nxt  = op.start ? 8'd0 : held_inst_r;
    vol_nxt   = op.start ? 8'd0 : held_vol_r;
    eff_nxt   = op.start ? 8'd0 : held_eff_r;
    param_nxt = 8'd0;
    case (op.kind)
      xpcu_pkg::OP_KEY:   key_nxt   = op.data;
      xpcu_pkg::OP_INST:  inst_nxt  = op.data;
      xpcu_pkg::OP_VOL:   vol_nxt   = op.data;
      xpcu_pkg::OP_EFF:   eff_nxt   = op.data;
      xpcu_pkg::OP_PARAM: param_nxt = op.data;
      default:            param_nxt = 8'd0;
    endcase
  end

  // Clamp missing or out-of-range keys to the empty-key code
  assign key_out = (key_nxt == 8'd0 || key_nxt >= empty_key_code) ? empty_key_code : key_nxt;

  // Output valid: load on a closing word, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && op.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Held fields and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      held_key_r  <= key_nxt;
      held_inst_r <= inst_nxt;
      held_vol_r  <= vol_nxt;
      held_eff_r  <= eff_nxt;
    end
    if (pop && op.last) begin
      key_r   <= key_out;
      inst_r  <= inst_nxt;
      vol_r   <= vol_nxt;
      eff_r   <= eff_nxt;
      param_r <= param_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign cell_key        = key_r;
  assign cell_instrument = inst_r;
  assign cell_volume     = vol_r;
  assign cell_effect     = eff_r;
  assign cell_param      = param_r;

endmodule

// ----- rtl/xm_pattern_cell_unpacker.sv -----
// Top level of the packed pattern cell unpacker: front, queue, back and config register.
// Takes one packed pattern word per cycle and delivers one five-field cell per cycle
// at most; a sustained rate of one word per clock holds as long as the result side
// does not stall. The front end classifies each word in the cycle it is accepted and
// writes it into a QUEUE_DEPTH-entry queue; the back end latches fields and places a
// finished cell in an output register, so a cell's last word passes through the queue
// and then the output register before the cell appears. in_stall rises only when the
// queue is full, which happens once the output register is held by out_stall and the
// queue has filled behind it. The empty-key code is written through the cfg port
// (always ready) and must only change while no cell is in flight.
module xm_pattern_cell_unpacker #(
  parameter int QUEUE_DEPTH = xpcu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cell_key,
  output logic [7:0] out_cell_instrument,
  output logic [7:0] out_cell_volume,
  output logic [7:0] out_cell_effect,
  output logic [7:0] out_cell_param,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic               push;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  xpcu_pkg::cell_op_t front_op;
  xpcu_pkg::cell_op_t head_op;
  logic [7:0]         empty_key_r;

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  // Empty-key code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_key_r <= xpcu_pkg::EMPTY_KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      empty_key_r <= cfg_data;
    end
  end

  xpcu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_byte (in_data_byte),
    .op        (front_op)
  );

  xpcu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  xpcu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_valid        (q_not_empty),
    .op              (head_op),
    .pop             (q_pop),
    .empty_key_code  (empty_key_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cell_key        (out_cell_key),
    .cell_instrument (out_cell_instrument),
    .cell_volume     (out_cell_volume),
    .cell_effect     (out_cell_effect),
    .cell_param      (out_cell_param)
  );

endmodule
